>>> hdl/csc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_pkg
// Shared types, action and refresh codes, calendar constants and the
// month start table of the calendar seconds clock.
// ----------------------------------------------------------------------------
package csc_pkg;

   // request actions
   localparam logic [2:0] ACT_TICK  = 3'd0;
   localparam logic [2:0] ACT_SET   = 3'd1;
   localparam logic [2:0] ACT_CHECK = 3'd2;
   localparam logic [2:0] ACT_FACE  = 3'd3;
   localparam logic [2:0] ACT_MARK  = 3'd4;

   // refresh codes
   localparam logic [1:0] REFRESH_NONE    = 2'd0;
   localparam logic [1:0] REFRESH_PARTIAL = 2'd1;
   localparam logic [1:0] REFRESH_FULL    = 2'd2;

   localparam logic [7:0]  YEAR_OFFSET_MAX = 8'd135;
   localparam logic [11:0] EPOCH_YEAR      = 12'd2000;
   localparam logic [31:0] DAY_SECS        = 32'd86400;
   localparam logic [15:0] FEB_FIRST_DAY   = 16'd31;
   localparam logic [15:0] MARCH_FIRST_DAY = 16'd60;
   localparam logic [15:0] CENTURY_DAYS    = 16'd36524;
   // day number of march 1st 1999 based dates, counted from 2000-01-01
   localparam logic [17:0] PRIOR_ERA_BASE  = 18'(-32'sd306);

   // reciprocals for exact division by constants
   localparam logic [25:0] DAY_RECIP  = 26'(((64'd1 << 35) + 64'd674) / 64'd675);
   localparam logic [14:0] LEAP_RECIP = 15'(((64'd1 << 23) + 64'd364) / 64'd365);
   localparam logic [16:0] YEAR_RECIP = 17'(((64'd1 << 25) + 64'd364) / 64'd365);
   localparam logic [15:0] MIN_RECIP  = 16'(((64'd1 << 19) + 64'd14) / 64'd15);
   localparam logic [9:0]  HOUR_RECIP = 10'(((64'd1 << 13) + 64'd14) / 64'd15);

   typedef struct packed {
      logic        valid;
      logic [2:0]  action;
      logic [31:0] count;
   } load_type;

   typedef struct packed {
      logic        valid;
      logic [2:0]  action;
      logic [15:0] day_num;
      logic        early;
      logic [10:0] min_total;
      logic [4:0]  hour;
      logic [5:0]  second;
      logic [7:0]  year_idx;
      logic [8:0]  day_of_year;
   } split_type;

   // first day of each month in a march based year
   function automatic logic [8:0] month_start(input logic [3:0] idx);
      logic [8:0] days;
      case (idx)
         4'd0:    days = 9'd0;
         4'd1:    days = 9'd31;
         4'd2:    days = 9'd61;
         4'd3:    days = 9'd92;
         4'd4:    days = 9'd122;
         4'd5:    days = 9'd153;
         4'd6:    days = 9'd184;
         4'd7:    days = 9'd214;
         4'd8:    days = 9'd245;
         4'd9:    days = 9'd275;
         4'd10:   days = 9'd306;
         4'd11:   days = 9'd337;
         4'd12:   days = 9'd367;
         default: days = 9'd0;
      endcase
      return days;
   endfunction

endpackage
`default_nettype wire

>>> hdl/csc_set_conv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_set_conv
// Request register and the two stages that turn a set-time date and time
// into a 32-bit seconds count.
// ----------------------------------------------------------------------------
module csc_set_conv (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [2:0]        req_action,
   input  logic [7:0]        req_year_offset,
   input  logic [3:0]        req_month_in,
   input  logic [4:0]        req_day_in,
   input  logic [4:0]        req_hour_in,
   input  logic [5:0]        req_minute_in,
   input  logic [5:0]        req_second_in,
   output csc_pkg::load_type load_out,
   input  logic              load_open
);

   logic        s0_open, s1_open, s2_open;
   logic        s0_valid_ff, s0_valid_in;
   logic        s1_valid_ff, s1_valid_in;
   logic        s2_valid_ff, s2_valid_in;
   logic [2:0]  s0_action_ff, s1_action_ff, s2_action_ff;
   logic [7:0]  s0_year_ff, s0_year_in;
   logic [3:0]  s0_month_ff;
   logic [4:0]  s0_day_ff, s0_hour_ff;
   logic [5:0]  s0_minute_ff, s0_second_ff;
   logic [17:0] s1_day_ff, s1_day_in;
   logic [16:0] s1_sod_ff, s1_sod_in;
   logic [31:0] s2_count_ff, s2_count_in;

   logic        early;
   logic [8:0]  yr;
   logic [3:0]  idx;
   logic [9:0]  doy;
   logic [16:0] ybase;

   always_comb begin
      s2_open = !s2_valid_ff || load_open;
      s1_open = !s1_valid_ff || s2_open;
      s0_open = !s0_valid_ff || s1_open;
      s0_valid_in = s0_open ? req_valid : s0_valid_ff;
      s1_valid_in = s1_open ? s0_valid_ff : s1_valid_ff;
      s2_valid_in = s2_open ? s1_valid_ff : s2_valid_ff;
   end

   assign req_stall = !s0_open;

   // saturate year offset
   assign s0_year_in = (req_year_offset > csc_pkg::YEAR_OFFSET_MAX) ?
                       csc_pkg::YEAR_OFFSET_MAX : req_year_offset;

   // day number and second of day of the set date
   always_comb begin
      early = (s0_month_ff <= 4'd2);
      yr    = {1'b0, s0_year_ff} - {8'b0, early};
      idx   = early ? (s0_month_ff + 4'd9) : (s0_month_ff - 4'd3);
      doy   = {1'b0, csc_pkg::month_start(idx)} + {5'b0, s0_day_ff} - 10'd1;
      ybase = ({9'b0, yr[7:0]} * 17'd365) + {11'b0, yr[7:2]}
              - {16'b0, (yr[7:0] >= 8'd100)} + {1'b0, csc_pkg::MARCH_FIRST_DAY};
      s1_day_in = (yr[8] ? csc_pkg::PRIOR_ERA_BASE : {1'b0, ybase})
                  + {{8{doy[9]}}, doy};
      s1_sod_in = ({12'b0, s0_hour_ff} * 17'd3600) + ({11'b0, s0_minute_ff} * 17'd60)
                  + {11'b0, s0_second_ff};
   end

   assign s2_count_in = ({{14{s1_day_ff[17]}}, s1_day_ff} * csc_pkg::DAY_SECS)
                        + {15'b0, s1_sod_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s0_valid_ff <= s0_valid_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
      if (s0_open && req_valid) begin
         s0_action_ff <= req_action;
         s0_year_ff   <= s0_year_in;
         s0_month_ff  <= req_month_in;
         s0_day_ff    <= req_day_in;
         s0_hour_ff   <= req_hour_in;
         s0_minute_ff <= req_minute_in;
         s0_second_ff <= req_second_in;
      end
      if (s1_open && s0_valid_ff) begin
         s1_action_ff <= s0_action_ff;
         s1_day_ff    <= s1_day_in;
         s1_sod_ff    <= s1_sod_in;
      end
      if (s2_open && s1_valid_ff) begin
         s2_action_ff <= s1_action_ff;
         s2_count_ff  <= s2_count_in;
      end
   end

   assign load_out.valid  = s2_valid_ff;
   assign load_out.action = s2_action_ff;
   assign load_out.count  = s2_count_ff;

endmodule
`default_nettype wire

>>> hdl/csc_count_conv.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_count_conv
// Seconds counter and the stages that split the count into day number,
// time of day and march based year and day of year.
// ----------------------------------------------------------------------------
module csc_count_conv (
   input  logic               clock,
   input  logic               reset,
   input  csc_pkg::load_type  load_in,
   output logic               load_open,
   output csc_pkg::split_type split_out,
   input  logic               split_open
);

   logic        s3_open, s4_open, s5_open, s6_open, s7_open;
   logic        s3_valid_ff, s3_valid_in, s4_valid_ff, s4_valid_in;
   logic        s5_valid_ff, s5_valid_in, s6_valid_ff, s6_valid_in;
   logic        s7_valid_ff, s7_valid_in;
   logic [2:0]  s3_action_ff, s4_action_ff, s5_action_ff, s6_action_ff, s7_action_ff;

   logic [31:0] count_ff, count_in;
   logic [31:0] s4_count_ff;
   logic [15:0] s4_day_ff, s4_day_in;
   logic [15:0] s5_day_ff, s6_day_ff, s7_day_ff;
   logic [16:0] s5_sod_ff, s5_sod_in, s6_sod_ff;
   logic        s5_early_ff, s5_early_in, s6_early_ff, s7_early_ff;
   logic [15:0] s5_doe_ff, s5_doe_in, s6_doe_ff;
   logic [5:0]  s5_quad_ff, s5_quad_in;
   logic        s5_cent_ff, s5_cent_in;
   logic [10:0] s6_mt_ff, s6_mt_in, s7_mt_ff;
   logic [7:0]  s6_yoe_ff, s6_yoe_in, s7_yoe_ff;
   logic [4:0]  s7_hour_ff, s7_hour_in;
   logic [5:0]  s7_sec_ff, s7_sec_in;
   logic [8:0]  s7_doy_ff, s7_doy_in;

   logic [50:0] day_prod;
   logic [31:0] day_base, sod_full;
   logic [28:0] quad_prod;
   logic [15:0] shifted_days;
   logic [32:0] year_prod;
   logic [30:0] min_prod;
   logic [16:0] sec_full;
   logic [18:0] hour_prod;
   logic [15:0] year_days, doy_full;

   always_comb begin
      s7_open = !s7_valid_ff || split_open;
      s6_open = !s6_valid_ff || s7_open;
      s5_open = !s5_valid_ff || s6_open;
      s4_open = !s4_valid_ff || s5_open;
      s3_open = !s3_valid_ff || s4_open;
      s3_valid_in = s3_open ? load_in.valid : s3_valid_ff;
      s4_valid_in = s4_open ? s3_valid_ff : s4_valid_ff;
      s5_valid_in = s5_open ? s4_valid_ff : s5_valid_ff;
      s6_valid_in = s6_open ? s5_valid_ff : s6_valid_ff;
      s7_valid_in = s7_open ? s6_valid_ff : s7_valid_ff;
   end

   assign load_open = s3_open;

   // seconds counter
   always_comb begin
      case (load_in.action)
         csc_pkg::ACT_SET:  count_in = load_in.count;
         csc_pkg::ACT_TICK: count_in = count_ff + 32'd1;
         default:           count_in = count_ff;
      endcase
   end

   // day number
   always_comb begin
      day_prod  = {26'b0, count_ff[31:7]} * {25'b0, csc_pkg::DAY_RECIP};
      s4_day_in = day_prod[50:35];
   end

   // second of day, day of era, early flag, quad and century terms
   always_comb begin
      day_base    = {16'b0, s4_day_ff} * csc_pkg::DAY_SECS;
      sod_full    = s4_count_ff - day_base;
      s5_sod_in   = sod_full[16:0];
      s5_early_in = (s4_day_ff < csc_pkg::MARCH_FIRST_DAY);
      s5_doe_in   = s5_early_in ? 16'd0 : (s4_day_ff - csc_pkg::MARCH_FIRST_DAY);
      quad_prod   = {15'b0, s5_doe_in[15:2]} * {14'b0, csc_pkg::LEAP_RECIP};
      s5_quad_in  = quad_prod[28:23];
      s5_cent_in  = (s5_doe_in >= csc_pkg::CENTURY_DAYS);
   end

   // minutes of day, year of era
   always_comb begin
      min_prod     = {16'b0, s5_sod_ff[16:2]} * {15'b0, csc_pkg::MIN_RECIP};
      s6_mt_in     = min_prod[29:19];
      shifted_days = s5_doe_ff - {10'b0, s5_quad_ff} + {15'b0, s5_cent_ff};
      year_prod    = {17'b0, shifted_days} * {16'b0, csc_pkg::YEAR_RECIP};
      s6_yoe_in    = year_prod[32:25];
   end

   // hour, second, day of year
   always_comb begin
      sec_full   = s6_sod_ff - ({6'b0, s6_mt_ff} * 17'd60);
      s7_sec_in  = sec_full[5:0];
      hour_prod  = {10'b0, s6_mt_ff[10:2]} * {9'b0, csc_pkg::HOUR_RECIP};
      s7_hour_in = hour_prod[17:13];
      year_days  = ({8'b0, s6_yoe_ff} * 16'd365) + {10'b0, s6_yoe_ff[7:2]}
                   - {15'b0, (s6_yoe_ff >= 8'd100)};
      doy_full   = s6_doe_ff - year_days;
      s7_doy_in  = doy_full[8:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
         s6_valid_ff <= 1'b0;
         s7_valid_ff <= 1'b0;
         count_ff    <= 32'd0;
      end else begin
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
         s5_valid_ff <= s5_valid_in;
         s6_valid_ff <= s6_valid_in;
         s7_valid_ff <= s7_valid_in;
         if (s3_open && load_in.valid) begin
            count_ff <= count_in;
         end
      end
      if (s3_open && load_in.valid) begin
         s3_action_ff <= load_in.action;
      end
      if (s4_open && s3_valid_ff) begin
         s4_action_ff <= s3_action_ff;
         s4_count_ff  <= count_ff;
         s4_day_ff    <= s4_day_in;
      end
      if (s5_open && s4_valid_ff) begin
         s5_action_ff <= s4_action_ff;
         s5_day_ff    <= s4_day_ff;
         s5_sod_ff    <= s5_sod_in;
         s5_early_ff  <= s5_early_in;
         s5_doe_ff    <= s5_doe_in;
         s5_quad_ff   <= s5_quad_in;
         s5_cent_ff   <= s5_cent_in;
      end
      if (s6_open && s5_valid_ff) begin
         s6_action_ff <= s5_action_ff;
         s6_day_ff    <= s5_day_ff;
         s6_early_ff  <= s5_early_ff;
         s6_sod_ff    <= s5_sod_ff;
         s6_doe_ff    <= s5_doe_ff;
         s6_mt_ff     <= s6_mt_in;
         s6_yoe_ff    <= s6_yoe_in;
      end
      if (s7_open && s6_valid_ff) begin
         s7_action_ff <= s6_action_ff;
         s7_day_ff    <= s6_day_ff;
         s7_early_ff  <= s6_early_ff;
         s7_mt_ff     <= s6_mt_ff;
         s7_yoe_ff    <= s6_yoe_ff;
         s7_hour_ff   <= s7_hour_in;
         s7_sec_ff    <= s7_sec_in;
         s7_doy_ff    <= s7_doy_in;
      end
   end

   assign split_out.valid       = s7_valid_ff;
   assign split_out.action      = s7_action_ff;
   assign split_out.day_num     = s7_day_ff;
   assign split_out.early       = s7_early_ff;
   assign split_out.min_total   = s7_mt_ff;
   assign split_out.hour        = s7_hour_ff;
   assign split_out.second      = s7_sec_ff;
   assign split_out.year_idx    = s7_yoe_ff;
   assign split_out.day_of_year = s7_doy_ff;

endmodule
`default_nettype wire

>>> hdl/csc_refresh.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// csc_refresh
// Final stage: calendar month and day, refresh decision, face select and
// the response register.
// ----------------------------------------------------------------------------
module csc_refresh (
   input  logic               clock,
   input  logic               reset,
   input  csc_pkg::split_type split_in,
   output logic               split_open,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_time_valid,
   output logic [11:0]        rsp_year_out,
   output logic [3:0]         rsp_month_out,
   output logic [4:0]         rsp_day_out,
   output logic [4:0]         rsp_hour_out,
   output logic [5:0]         rsp_minute_out,
   output logic [5:0]         rsp_second_out,
   output logic [1:0]         rsp_refresh_code,
   output logic               rsp_face_out
);

   logic        open, enter;
   logic        valid_ff, valid_in;
   logic        time_set_ff, time_set_in;
   logic        force_ff, force_in;
   logic        seen_ff, seen_in;
   logic [5:0]  last_min_ff, last_min_in;
   logic [15:0] last_day_ff, last_day_in;
   logic        face_ff, face_in;

   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [5:0]  second_ff, second_in;
   logic [1:0]  refresh_ff, refresh_in;

   logic [10:0] hour_mins, min_full;
   logic [5:0]  minute;
   logic [3:0]  mp, mm, dmon;
   logic [8:0]  dd_full;
   logic [4:0]  dday;
   logic [11:0] dyear;
   logic [15:0] feb_day;

   always_comb begin
      open     = !valid_ff || !rsp_stall;
      enter    = open && split_in.valid;
      valid_in = open ? split_in.valid : valid_ff;
   end

   assign split_open = open;

   // calendar fields
   always_comb begin
      hour_mins = {6'b0, split_in.hour} * 11'd60;
      min_full  = split_in.min_total - hour_mins;
      minute    = min_full[5:0];
      mp = 4'd0;
      for (int k = 1; k < 12; k++) begin
         if (split_in.day_of_year >= csc_pkg::month_start(4'(k))) begin
            mp = 4'(k);
         end
      end
      dd_full = split_in.day_of_year - csc_pkg::month_start(mp) + 9'd1;
      mm      = (mp < 4'd10) ? (mp + 4'd3) : (mp - 4'd9);
      feb_day = split_in.day_num - 16'd30;
      if (split_in.early) begin
         if (split_in.day_num < csc_pkg::FEB_FIRST_DAY) begin
            dmon = 4'd1;
            dday = split_in.day_num[4:0] + 5'd1;
         end else begin
            dmon = 4'd2;
            dday = feb_day[4:0];
         end
         dyear = csc_pkg::EPOCH_YEAR;
      end else begin
         dmon  = mm;
         dday  = dd_full[4:0];
         dyear = csc_pkg::EPOCH_YEAR + {4'b0, split_in.year_idx} + {11'b0, (mm <= 4'd2)};
      end
   end

   // flags and refresh decision
   always_comb begin
      time_set_in = time_set_ff;
      force_in    = force_ff;
      seen_in     = seen_ff;
      last_min_in = last_min_ff;
      last_day_in = last_day_ff;
      face_in     = face_ff;
      refresh_in  = csc_pkg::REFRESH_NONE;
      case (split_in.action)
         csc_pkg::ACT_SET: begin
            time_set_in = 1'b1;
            force_in    = 1'b1;
            seen_in     = 1'b0;
         end
         csc_pkg::ACT_FACE: begin
            face_in  = !face_ff;
            force_in = 1'b1;
            seen_in  = 1'b0;
         end
         default: begin
         end
      endcase
      if (time_set_in) begin
         case (split_in.action)
            csc_pkg::ACT_CHECK: begin
               if (force_in) begin
                  force_in   = 1'b0;
                  refresh_in = csc_pkg::REFRESH_FULL;
               end else if (!seen_in || (split_in.day_num != last_day_in)) begin
                  last_day_in = split_in.day_num;
                  last_min_in = minute;
                  seen_in     = 1'b1;
                  refresh_in  = csc_pkg::REFRESH_FULL;
               end else if (minute != last_min_in) begin
                  last_min_in = minute;
                  refresh_in  = csc_pkg::REFRESH_PARTIAL;
               end
            end
            csc_pkg::ACT_MARK: begin
               last_day_in = split_in.day_num;
               last_min_in = minute;
               seen_in     = 1'b1;
            end
            default: begin
            end
         endcase
         year_in   = dyear;
         month_in  = dmon;
         day_in    = dday;
         hour_in   = split_in.hour;
         minute_in = minute;
         second_in = split_in.second;
      end else begin
         year_in   = 12'd0;
         month_in  = 4'd0;
         day_in    = 5'd0;
         hour_in   = 5'd0;
         minute_in = 6'd0;
         second_in = 6'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         time_set_ff <= 1'b0;
         force_ff    <= 1'b0;
         seen_ff     <= 1'b0;
         last_min_ff <= 6'd0;
         last_day_ff <= 16'd0;
         face_ff     <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (enter) begin
            time_set_ff <= time_set_in;
            force_ff    <= force_in;
            seen_ff     <= seen_in;
            last_min_ff <= last_min_in;
            last_day_ff <= last_day_in;
            face_ff     <= face_in;
         end
      end
      if (enter) begin
         year_ff    <= year_in;
         month_ff   <= month_in;
         day_ff     <= day_in;
         hour_ff    <= hour_in;
         minute_ff  <= minute_in;
         second_ff  <= second_in;
         refresh_ff <= refresh_in;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_time_valid   = time_set_ff;
   assign rsp_year_out     = year_ff;
   assign rsp_month_out    = month_ff;
   assign rsp_day_out      = day_ff;
   assign rsp_hour_out     = hour_ff;
   assign rsp_minute_out   = minute_ff;
   assign rsp_second_out   = second_ff;
   assign rsp_refresh_code = refresh_ff;
   assign rsp_face_out     = face_ff;

endmodule
`default_nettype wire

>>> hdl/calendar_seconds_clock_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted request passes the request register, 7 pipeline
// stages and the response register before its response is presented.
// Throughput: one request per cycle; each stage holds only while all stages
// after it are full and the response is stalled.
// Reset: synchronous; clears all valid bits, the seconds count, the flags,
// the last seen minute and day and the face select.
// ----------------------------------------------------------------------------
// calendar_seconds_clock_top
// Calendar clock on a 32-bit seconds count since 2000-01-01 with set-time,
// tick, face toggle and display refresh tracking.
// ----------------------------------------------------------------------------
module calendar_seconds_clock_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_action,
   input  logic [7:0]  req_year_offset,
   input  logic [3:0]  req_month_in,
   input  logic [4:0]  req_day_in,
   input  logic [4:0]  req_hour_in,
   input  logic [5:0]  req_minute_in,
   input  logic [5:0]  req_second_in,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_time_valid,
   output logic [11:0] rsp_year_out,
   output logic [3:0]  rsp_month_out,
   output logic [4:0]  rsp_day_out,
   output logic [4:0]  rsp_hour_out,
   output logic [5:0]  rsp_minute_out,
   output logic [5:0]  rsp_second_out,
   output logic [1:0]  rsp_refresh_code,
   output logic        rsp_face_out
);

   csc_pkg::load_type  load;
   logic               load_open;
   csc_pkg::split_type split;
   logic               split_open;

   csc_set_conv u_set_conv (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_year_offset (req_year_offset),
      .req_month_in    (req_month_in),
      .req_day_in      (req_day_in),
      .req_hour_in     (req_hour_in),
      .req_minute_in   (req_minute_in),
      .req_second_in   (req_second_in),
      .load_out        (load),
      .load_open       (load_open)
   );

   csc_count_conv u_count_conv (
      .clock      (clock),
      .reset      (reset),
      .load_in    (load),
      .load_open  (load_open),
      .split_out  (split),
      .split_open (split_open)
   );

   csc_refresh u_refresh (
      .clock            (clock),
      .reset            (reset),
      .split_in         (split),
      .split_open       (split_open),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_time_valid   (rsp_time_valid),
      .rsp_year_out     (rsp_year_out),
      .rsp_month_out    (rsp_month_out),
      .rsp_day_out      (rsp_day_out),
      .rsp_hour_out     (rsp_hour_out),
      .rsp_minute_out   (rsp_minute_out),
      .rsp_second_out   (rsp_second_out),
      .rsp_refresh_code (rsp_refresh_code),
      .rsp_face_out     (rsp_face_out)
   );

endmodule
`default_nettype wire
